// ===== design/mnsq_pkg.sv =====
// Shared constants, codes and types of the Markov note sequencer.
`timescale 1ns / 1ps
package mnsq_pkg;

   // Table geometry
   localparam int ENTRIES_PER_ROW = 8;
   localparam int WEIGHT_BITS     = 8;
   localparam int RAND_BITS       = 16;
   localparam int NUM_ROWS        = 131;

   // Port field widths
   localparam int OP_W     = 3;
   localparam int CODE_W   = 8;
   localparam int WEIGHT_W = 8;
   localparam int RAND_W   = 16;
   localparam int KIND_W   = 2;
   localparam int NOTE_W   = 7;

   // Derived widths
   localparam int ROW_AW    = $clog2(NUM_ROWS);
   localparam int CNT_W     = $clog2(ENTRIES_PER_ROW + 1);
   localparam int TOT_W     = $clog2(ENTRIES_PER_ROW * ((1 << WEIGHT_BITS) - 1) + 1);
   localparam int IDX_W     = (ENTRIES_PER_ROW > 1) ? $clog2(ENTRIES_PER_ROW) : 1;
   localparam int ENT_DEPTH = NUM_ROWS * ENTRIES_PER_ROW;
   localparam int ENT_AW    = $clog2(ENT_DEPTH);
   localparam int PROD_W    = RAND_BITS + TOT_W;

   // Special codes
   localparam logic [CODE_W-1:0] CODE_REST    = 8'd128;
   localparam logic [CODE_W-1:0] CODE_SUSTAIN = 8'd129;
   localparam logic [CODE_W-1:0] CODE_NONE    = 8'd130;
   localparam logic [CODE_W-1:0] ROW_INITIAL  = 8'd130;

   // Operations
   localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
   localparam logic [OP_W-1:0] OP_START = 3'd2;
   localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
   localparam logic [OP_W-1:0] OP_STEP  = 3'd4;

   // Event kinds
   localparam logic [KIND_W-1:0] EV_OFF   = 2'd0;
   localparam logic [KIND_W-1:0] EV_ON    = 2'd1;
   localparam logic [KIND_W-1:0] EV_EMPTY = 2'd2;
   localparam logic [KIND_W-1:0] EV_FULL  = 2'd3;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [TOT_W-1:0] total;
   } row_data_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [TOT_W-1:0]  cum;
   } entry_type;

   typedef struct packed {
      logic              rd_en;
      logic [ROW_AW-1:0] rd_addr;
      logic              wr_en;
      logic [ROW_AW-1:0] wr_addr;
      row_data_type      wr_data;
      logic              clr;
   } row_req_type;

   typedef struct packed {
      logic              rd_en;
      logic [ENT_AW-1:0] rd_addr;
      logic              wr_en;
      logic [ENT_AW-1:0] wr_addr;
      entry_type         wr_data;
   } ent_req_type;

endpackage

// ===== design/mnsq_row_mem.sv =====
// Per-row count and total memory with valid bits so that clear empties all rows at once.
`timescale 1ns / 1ps
module mnsq_row_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  mnsq_pkg::row_req_type req,
   output mnsq_pkg::row_data_type rd_data
);
   import mnsq_pkg::*;

   row_data_type          mem [NUM_ROWS];
   logic [NUM_ROWS-1:0]   valid_ff;
   row_data_type          rd_data_ff;
   logic                  rd_valid_ff;

   // Track written rows; clear drops them all at once
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.clr) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.wr_addr] <= 1'b1;
      end
   end

   // Write and registered read
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff  <= mem[req.rd_addr];
         rd_valid_ff <= valid_ff[req.rd_addr];
      end
   end

   // A row never written since clear reads as empty
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== design/mnsq_entry_mem.sv =====
// Successor entry store: one write port, one registered read port.
`timescale 1ns / 1ps
module mnsq_entry_mem (
   input  logic                  clock,
   input  mnsq_pkg::ent_req_type req,
   output mnsq_pkg::entry_type   rd_data
);
   import mnsq_pkg::*;

   entry_type mem [ENT_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mnsq_ctrl.sv =====
// Sequencer control: decode, row lookup, weighted search, play state, result output.
`timescale 1ns / 1ps
module mnsq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mnsq_pkg::OP_W-1:0]     req_op,
   input  logic [mnsq_pkg::CODE_W-1:0]   req_from_code,
   input  logic [mnsq_pkg::CODE_W-1:0]   req_to_code,
   input  logic [mnsq_pkg::WEIGHT_W-1:0] req_weight,
   input  logic [mnsq_pkg::RAND_W-1:0]   req_rand_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mnsq_pkg::KIND_W-1:0]   rsp_event_kind,
   output logic [mnsq_pkg::NOTE_W-1:0]   rsp_note,
   output logic                        rsp_last,
   output mnsq_pkg::row_req_type       row_req,
   input  mnsq_pkg::row_data_type      row_rd,
   output mnsq_pkg::ent_req_type       ent_req,
   input  mnsq_pkg::entry_type         ent_rd
);
   import mnsq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_ROW, S_MUL, S_SEARCH, S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      P_IDLE, P_STARTED, P_PLAYING, P_STOPPING
   } play_type;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
      logic [NOTE_W-1:0] note;
   } slot_type;

   state_type            state_ff;
   play_type             play_ff;
   logic [CODE_W-1:0]    current_ff;
   logic [CODE_W-1:0]    held_ff;

   logic [OP_W-1:0]      op_ff;
   logic [CODE_W-1:0]    from_ff;
   logic [CODE_W-1:0]    to_ff;
   logic [WEIGHT_BITS-1:0] weight_ff;
   logic [RAND_BITS-1:0] rand_ff;

   logic [ROW_AW-1:0]    row_ff;
   logic [ENT_AW-1:0]    base_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [IDX_W-1:0]     idx_ff;

   slot_type             slot_a_ff;
   slot_type             slot_b_ff;

   logic                 rsp_valid_ff;
   logic [KIND_W-1:0]    rsp_kind_ff;
   logic [NOTE_W-1:0]    rsp_note_ff;
   logic                 rsp_last_ff;

   logic                 load_bad;
   logic [ROW_AW-1:0]    step_row;
   logic [TOT_W-1:0]     new_total;
   logic [TOT_W-1:0]     draw;
   logic                 hit;
   logic [CODE_W-1:0]    next_code;
   logic                 off_c;
   logic                 on_c;
   slot_type             off_slot;
   slot_type             on_slot;
   slot_type             idle_slot;
   logic                 out_free;
   logic                 emit_fire;

   // Decode helpers
   assign load_bad  = (from_ff > CODE_NONE) || (to_ff > CODE_SUSTAIN);
   assign step_row  = (play_ff == P_STARTED) ? ROW_AW'(ROW_INITIAL) : ROW_AW'(current_ff);
   assign new_total = TOT_W'(row_rd.total + TOT_W'(weight_ff));

   // Scale the random word to a draw in 1..total and test the current entry
   assign draw      = TOT_W'(prod_ff >> RAND_BITS) + TOT_W'(1);
   assign hit       = (ent_rd.cum >= draw) || (idx_ff == IDX_W'(cnt_ff - CNT_W'(1)));
   assign next_code = ent_rd.code;

   // Note-off and note-on rules for the chosen successor
   assign off_c = (play_ff == P_PLAYING) && (next_code != CODE_SUSTAIN) && (held_ff < CODE_REST);
   assign on_c  = next_code < CODE_REST;

   assign off_slot  = '{valid: 1'b1, kind: EV_OFF, note: NOTE_W'(held_ff)};
   assign on_slot   = '{valid: on_c, kind: EV_ON, note: NOTE_W'(next_code)};
   assign idle_slot = '{valid: 1'b0, kind: EV_OFF, note: '0};

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_fire = (state_ff == S_EMIT) && slot_a_ff.valid && out_free;

   // Row memory requests
   always_comb begin
      row_req         = '0;
      row_req.rd_addr = (op_ff == OP_STEP) ? step_row : ROW_AW'(from_ff);
      row_req.wr_addr = row_ff;
      row_req.wr_data = '{count: CNT_W'(row_rd.count + CNT_W'(1)), total: new_total};
      if (state_ff == S_DECODE) begin
         row_req.rd_en = ((op_ff == OP_LOAD) && !load_bad) ||
                         ((op_ff == OP_STEP) &&
                          ((play_ff == P_STARTED) || (play_ff == P_PLAYING)));
         row_req.clr   = (op_ff == OP_CLEAR);
      end
      if (state_ff == S_ROW && op_ff == OP_LOAD) begin
         row_req.wr_en = (row_rd.count < CNT_W'(ENTRIES_PER_ROW));
      end
   end

   // Entry memory requests
   always_comb begin
      ent_req         = '0;
      ent_req.wr_addr = ENT_AW'(base_ff + ENT_AW'(row_rd.count));
      ent_req.wr_data = '{code: to_ff, cum: new_total};
      ent_req.rd_addr = (state_ff == S_MUL) ? base_ff :
                        ENT_AW'(base_ff + ENT_AW'(idx_ff) + ENT_AW'(1));
      if (state_ff == S_ROW && op_ff == OP_LOAD) begin
         ent_req.wr_en = (row_rd.count < CNT_W'(ENTRIES_PER_ROW));
      end
      if (state_ff == S_MUL) begin
         ent_req.rd_en = 1'b1;
      end
      if (state_ff == S_SEARCH && !hit) begin
         ent_req.rd_en = 1'b1;
      end
   end

   // Sequencer state, play state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         play_ff      <= P_IDLE;
         current_ff   <= CODE_NONE;
         held_ff      <= CODE_NONE;
         slot_a_ff    <= '0;
         slot_b_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the output once the receiver takes it and nothing new follows
         if (rsp_valid_ff && !rsp_stall && !emit_fire) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff     <= req_op;
                  from_ff   <= req_from_code;
                  to_ff     <= req_to_code;
                  weight_ff <= WEIGHT_BITS'(req_weight);
                  rand_ff   <= RAND_BITS'(req_rand_word);
                  state_ff  <= S_DECODE;
               end
            end

            S_DECODE: begin
               unique case (op_ff)
                  OP_LOAD: begin
                     row_ff   <= ROW_AW'(from_ff);
                     base_ff  <= ENT_AW'(ROW_AW'(from_ff) * ENTRIES_PER_ROW);
                     state_ff <= load_bad ? S_IDLE : S_ROW;
                  end
                  OP_START: begin
                     if (play_ff == P_IDLE) begin
                        play_ff <= P_STARTED;
                     end
                     state_ff <= S_IDLE;
                  end
                  OP_STOP: begin
                     if (play_ff == P_STARTED) begin
                        play_ff <= P_IDLE;
                     end else if (play_ff == P_PLAYING) begin
                        play_ff <= P_STOPPING;
                     end
                     state_ff <= S_IDLE;
                  end
                  OP_STEP: begin
                     row_ff  <= step_row;
                     base_ff <= ENT_AW'(step_row * ENTRIES_PER_ROW);
                     if (play_ff == P_STARTED || play_ff == P_PLAYING) begin
                        state_ff <= S_ROW;
                     end else if (play_ff == P_STOPPING) begin
                        // Release the held note and return to idle
                        slot_a_ff  <= (held_ff < CODE_REST) ? off_slot : idle_slot;
                        slot_b_ff  <= idle_slot;
                        held_ff    <= CODE_NONE;
                        current_ff <= CODE_NONE;
                        play_ff    <= P_IDLE;
                        state_ff   <= S_EMIT;
                     end else begin
                        state_ff <= S_IDLE;
                     end
                  end
                  default: begin
                     state_ff <= S_IDLE;
                  end
               endcase
            end

            S_ROW: begin
               cnt_ff  <= row_rd.count;
               prod_ff <= PROD_W'(rand_ff) * PROD_W'(row_rd.total);
               idx_ff  <= '0;
               if (op_ff == OP_LOAD) begin
                  if (row_rd.count < CNT_W'(ENTRIES_PER_ROW)) begin
                     state_ff <= S_IDLE;
                  end else begin
                     slot_a_ff <= '{valid: 1'b1, kind: EV_FULL, note: '0};
                     slot_b_ff <= idle_slot;
                     state_ff  <= S_EMIT;
                  end
               end else if (row_rd.count == '0 || row_rd.total == '0) begin
                  slot_a_ff <= '{valid: 1'b1, kind: EV_EMPTY, note: '0};
                  slot_b_ff <= idle_slot;
                  state_ff  <= S_EMIT;
               end else begin
                  state_ff <= S_MUL;
               end
            end

            S_MUL: begin
               state_ff <= S_SEARCH;
            end

            S_SEARCH: begin
               if (hit) begin
                  slot_a_ff  <= off_c ? off_slot : on_slot;
                  slot_b_ff  <= off_c ? on_slot : idle_slot;
                  held_ff    <= on_c ? next_code :
                                ((play_ff == P_STARTED || off_c) ? CODE_NONE : held_ff);
                  current_ff <= next_code;
                  play_ff    <= P_PLAYING;
                  state_ff   <= S_EMIT;
               end else begin
                  idx_ff <= IDX_W'(idx_ff + IDX_W'(1));
               end
            end

            S_EMIT: begin
               if (!slot_a_ff.valid) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= slot_a_ff.kind;
                  rsp_note_ff  <= slot_a_ff.note;
                  rsp_last_ff  <= !slot_b_ff.valid;
                  slot_a_ff    <= slot_b_ff;
                  slot_b_ff    <= idle_slot;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_note       = rsp_note_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== design/markov_note_sequencer_core.sv =====
// Top level of the Markov note sequencer: control plus row and entry memories.
//
// Usage: the request channel (req_valid, req_stall, req_* fields) takes one
// operation at a time: load a weighted successor into a row, clear all rows,
// start, stop, or step. The response channel (rsp_valid, rsp_stall) returns
// zero, one or two events per request; rsp_last marks the final one.
// Timing: each request is taken while req_stall is low and then worked through a
// small sequencer. Clear, start, stop and ignored requests end after decode; a
// load reads the row, then writes entry and row, and emits a full event when
// the row is full. A step reads the row and scales the random word, then does
// one entry-memory read per entry searched (1 to ENTRIES_PER_ROW), then sends
// each event in turn. The entry memory read port, one entry a cycle, sets the
// step time.
// Reset: play state goes to idle, no note is held, every row reads empty;
// the entry store itself is not cleared and needs no sweep.
// Backpressure: while rsp_stall is high the current event holds in the output
// register; the sequencer waits with further events and keeps req_stall high.
`timescale 1ns / 1ps
module markov_note_sequencer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mnsq_pkg::OP_W-1:0]     req_op,
   input  logic [mnsq_pkg::CODE_W-1:0]   req_from_code,
   input  logic [mnsq_pkg::CODE_W-1:0]   req_to_code,
   input  logic [mnsq_pkg::WEIGHT_W-1:0] req_weight,
   input  logic [mnsq_pkg::RAND_W-1:0]   req_rand_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mnsq_pkg::KIND_W-1:0]   rsp_event_kind,
   output logic [mnsq_pkg::NOTE_W-1:0]   rsp_note,
   output logic                          rsp_last
);
   import mnsq_pkg::*;

   row_req_type  row_req;
   row_data_type row_rd;
   ent_req_type  ent_req;
   entry_type    ent_rd;

   mnsq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_from_code  (req_from_code),
      .req_to_code    (req_to_code),
      .req_weight     (req_weight),
      .req_rand_word  (req_rand_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_note       (rsp_note),
      .rsp_last       (rsp_last),
      .row_req        (row_req),
      .row_rd         (row_rd),
      .ent_req        (ent_req),
      .ent_rd         (ent_rd)
   );

   mnsq_row_mem u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (row_req),
      .rd_data (row_rd)
   );

   mnsq_entry_mem u_entry_mem (
      .clock   (clock),
      .req     (ent_req),
      .rd_data (ent_rd)
   );

endmodule

// ===== bench/note_event_checker.sv =====
// Checker for the note sequencer: predicts the event stream and compares it with the block.
`timescale 1ns / 1ps
module note_event_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [mnsq_pkg::OP_W-1:0]     req_op,
   input  logic [mnsq_pkg::CODE_W-1:0]   req_from_code,
   input  logic [mnsq_pkg::CODE_W-1:0]   req_to_code,
   input  logic [mnsq_pkg::WEIGHT_W-1:0] req_weight,
   input  logic [mnsq_pkg::RAND_W-1:0]   req_rand_word,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [mnsq_pkg::KIND_W-1:0]   rsp_event_kind,
   input  logic [mnsq_pkg::NOTE_W-1:0]   rsp_note,
   input  logic                          rsp_last,
   output int                            fail_count,
   output int                            pending_events
);
   import mnsq_pkg::*;

   typedef enum logic [1:0] {
      PLAY_IDLE,
      PLAY_STARTED,
      PLAY_RUNNING,
      PLAY_STOPPING
   } play_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [NOTE_W-1:0] note;
      logic              last;
   } note_event_type;

   // Own copy of the transition table and the play state
   logic [CODE_W-1:0] succ_code  [NUM_ROWS*ENTRIES_PER_ROW];
   logic [TOT_W-1:0]  succ_cum   [NUM_ROWS*ENTRIES_PER_ROW];
   logic [CNT_W-1:0]  fill       [NUM_ROWS];
   logic [TOT_W-1:0]  weight_sum [NUM_ROWS];
   play_type          play;
   logic [CODE_W-1:0] cur_code;
   logic [CODE_W-1:0] sounding;

   note_event_type expected_events[$];

   initial begin
      fail_count     = 0;
      pending_events = 0;
   end

   function automatic note_event_type make_event(input logic [KIND_W-1:0] kind,
                                                 input logic [NOTE_W-1:0] note);
      note_event_type ev;
      ev.kind = kind;
      ev.note = note;
      ev.last = 1'b0;
      return ev;
   endfunction

   // Scale the random word to a draw in 1..total and take the first entry reaching it
   function automatic bit draw_successor(input int row, input logic [RAND_W-1:0] rnd,
                                         output logic [CODE_W-1:0] code);
      longint unsigned product;
      longint unsigned draw_val;
      int              base;
      bit              hit;
      code = CODE_NONE;
      if (fill[row] == 0 || weight_sum[row] == 0) begin
         return 1'b0;
      end
      base     = row * ENTRIES_PER_ROW;
      product  = (longint'(rnd) & ((64'd1 << RAND_BITS) - 1)) * longint'(weight_sum[row]);
      draw_val = (product >> RAND_BITS) + 1;
      code     = succ_code[base + int'(fill[row]) - 1];
      hit      = 1'b0;
      for (int i = 0; i < int'(fill[row]); i++) begin
         if (!hit && longint'(succ_cum[base + i]) >= draw_val) begin
            code = succ_code[base + i];
            hit  = 1'b1;
         end
      end
      return 1'b1;
   endfunction

   // Apply one accepted request to the model and queue the events it causes
   function automatic void predict_events(input logic [OP_W-1:0]     op,
                                          input logic [CODE_W-1:0]   from_c,
                                          input logic [CODE_W-1:0]   to_c,
                                          input logic [WEIGHT_W-1:0] wt,
                                          input logic [RAND_W-1:0]   rnd);
      note_event_type    produced[$];
      logic [CODE_W-1:0] next_code;
      int                slot;
      case (op)
         OP_LOAD: begin
            if (from_c < NUM_ROWS && to_c <= CODE_SUSTAIN) begin
               if (fill[from_c] >= ENTRIES_PER_ROW) begin
                  produced.push_back(make_event(EV_FULL, '0));
               end else begin
                  slot = int'(from_c) * ENTRIES_PER_ROW + int'(fill[from_c]);
                  weight_sum[from_c] = weight_sum[from_c]
                                       + TOT_W'(wt & WEIGHT_W'((1 << WEIGHT_BITS) - 1));
                  succ_code[slot] = to_c;
                  succ_cum[slot]  = weight_sum[from_c];
                  fill[from_c]    = fill[from_c] + 1'b1;
               end
            end
         end
         OP_CLEAR: begin
            for (int r = 0; r < NUM_ROWS; r++) begin
               fill[r]       = '0;
               weight_sum[r] = '0;
            end
         end
         OP_START: begin
            if (play == PLAY_IDLE) play = PLAY_STARTED;
         end
         OP_STOP: begin
            if (play == PLAY_STARTED) play = PLAY_IDLE;
            else if (play == PLAY_RUNNING) play = PLAY_STOPPING;
         end
         OP_STEP: begin
            case (play)
               PLAY_STARTED: begin
                  if (!draw_successor(ROW_INITIAL, rnd, next_code)) begin
                     produced.push_back(make_event(EV_EMPTY, '0));
                  end else begin
                     if (next_code < CODE_REST) begin
                        produced.push_back(make_event(EV_ON, next_code[NOTE_W-1:0]));
                        sounding = next_code;
                     end else begin
                        sounding = CODE_NONE;
                     end
                     cur_code = next_code;
                     play     = PLAY_RUNNING;
                  end
               end
               PLAY_RUNNING: begin
                  if (!draw_successor(int'(cur_code), rnd, next_code)) begin
                     produced.push_back(make_event(EV_EMPTY, '0));
                  end else begin
                     // release the held note unless the successor sustains it
                     if (next_code != CODE_SUSTAIN && sounding < CODE_REST) begin
                        produced.push_back(make_event(EV_OFF, sounding[NOTE_W-1:0]));
                        sounding = CODE_NONE;
                     end
                     if (next_code < CODE_REST) begin
                        produced.push_back(make_event(EV_ON, next_code[NOTE_W-1:0]));
                        sounding = next_code;
                     end
                     cur_code = next_code;
                  end
               end
               PLAY_STOPPING: begin
                  if (sounding < CODE_REST) begin
                     produced.push_back(make_event(EV_OFF, sounding[NOTE_W-1:0]));
                  end
                  sounding = CODE_NONE;
                  cur_code = CODE_NONE;
                  play     = PLAY_IDLE;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      if (produced.size() > 0) begin
         produced[produced.size()-1].last = 1'b1;
      end
      foreach (produced[i]) expected_events.push_back(produced[i]);
   endfunction

   // Track both channels on the rising edge; requests first, then responses
   always @(posedge clock) begin
      note_event_type want;
      if (reset) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            fill[r]       = '0;
            weight_sum[r] = '0;
         end
         for (int s = 0; s < NUM_ROWS * ENTRIES_PER_ROW; s++) begin
            succ_code[s] = '0;
            succ_cum[s]  = '0;
         end
         play     = PLAY_IDLE;
         cur_code = CODE_NONE;
         sounding = CODE_NONE;
         expected_events.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_events(req_op, req_from_code, req_to_code, req_weight, req_rand_word);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               if (fail_count < 10) begin
                  $display("%0t: unexpected event kind=%0d note=%0d last=%0b", $realtime,
                           rsp_event_kind, rsp_note, rsp_last);
               end
               fail_count++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_kind !== want.kind || rsp_note !== want.note ||
                   rsp_last !== want.last) begin
                  if (fail_count < 10) begin
                     $display("%0t: mismatch (exp/got) kind %0d/%0d note %0d/%0d last %0b/%0b",
                              $realtime, want.kind, rsp_event_kind, want.note, rsp_note,
                              want.last, rsp_last);
                  end
                  fail_count++;
               end
            end
         end
      end
      pending_events = expected_events.size();
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the note sequencer bench: clock, reset, request traffic, output stalls and verdict.
`timescale 1ns / 1ps
module testbench;
   import mnsq_pkg::*;

   localparam int ITEMS       = 950;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 500000;
   localparam int TAIL_CYCLES = 40;

   // operation codes the block has no use for
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_op;
   logic [CODE_W-1:0]   req_from_code;
   logic [CODE_W-1:0]   req_to_code;
   logic [WEIGHT_W-1:0] req_weight;
   logic [RAND_W-1:0]   req_rand_word;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [KIND_W-1:0]   rsp_event_kind;
   logic [NOTE_W-1:0]   rsp_note;
   logic                rsp_last;
   int                  fail_count;
   int                  pending_events;

   int cycle_count  = 0;
   int sent_count   = 0;
   int burst_left   = 0;
   bit hold_request = 1'b0;

   markov_note_sequencer_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_from_code  (req_from_code),
      .req_to_code    (req_to_code),
      .req_weight     (req_weight),
      .req_rand_word  (req_rand_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_note       (rsp_note),
      .rsp_last       (rsp_last)
   );

   note_event_checker event_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_from_code  (req_from_code),
      .req_to_code    (req_to_code),
      .req_weight     (req_weight),
      .req_rand_word  (req_rand_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_note       (rsp_note),
      .rsp_last       (rsp_last),
      .fail_count     (fail_count),
      .pending_events (pending_events)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Offer one request at a falling edge and hold it until the transfer happens
   task automatic send_item(input logic [OP_W-1:0]     op,
                            input logic [CODE_W-1:0]   from_c,
                            input logic [CODE_W-1:0]   to_c,
                            input logic [WEIGHT_W-1:0] wt,
                            input logic [RAND_W-1:0]   rnd);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) == 0) begin
            gap        = 0;
            burst_left = $urandom_range(60, 120);
         end else begin
            gap        = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 4);
            burst_left = $urandom_range(1, 24);
         end
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_op        = op;
      req_from_code = from_c;
      req_to_code   = to_c;
      req_weight    = wt;
      req_rand_word = rnd;
      req_valid     = 1'b1;
      do @(posedge clock); while (req_stall);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_step(input logic [RAND_W-1:0] rnd);
      send_item(OP_STEP, '0, '0, '0, rnd);
   endtask

   task automatic send_noise();
      send_item(OP_W'($urandom_range(0, 7)), CODE_W'($urandom), CODE_W'($urandom),
                WEIGHT_W'($urandom), RAND_W'($urandom));
   endtask

   function automatic logic [CODE_W-1:0] random_code();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return CODE_REST;
      if (pick == 1) return CODE_SUSTAIN;
      if (pick == 2) return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd127;
      return CODE_W'($urandom_range(0, 127));
   endfunction

   // Build a small chain over a pool of codes, then play it for a while
   task automatic play_song(input bit with_hold);
      logic [CODE_W-1:0] pool [6];
      logic [CODE_W-1:0] row;
      logic [RAND_W-1:0] rnd;
      int                pool_n;
      int                loads;
      int                steps;
      if ($urandom_range(0, 3) != 0) send_item(OP_CLEAR, '0, '0, '0, '0);
      pool_n = $urandom_range(2, 6);
      for (int i = 0; i < pool_n; i++) pool[i] = random_code();
      for (int r = -1; r < pool_n; r++) begin
         row   = (r < 0) ? ROW_INITIAL : pool[r];
         loads = ($urandom_range(0, 15) == 0) ? 0 :
                 ($urandom_range(0, 9) == 0) ? ENTRIES_PER_ROW + 1 : $urandom_range(1, 6);
         for (int k = 0; k < loads; k++) begin
            send_item(OP_LOAD, row, pool[$urandom_range(0, pool_n - 1)],
                      ($urandom_range(0, 15) == 0) ? 8'd0 : WEIGHT_W'($urandom_range(1, 255)),
                      RAND_W'($urandom));
            if ($urandom_range(0, 19) == 0) send_noise();
         end
      end
      if (with_hold) hold_request = 1'b1;
      send_item(OP_START, '0, '0, '0, '0);
      steps = $urandom_range(4, 40);
      for (int s = 0; s < steps; s++) begin
         case ($urandom_range(0, 29))
            0: begin
               send_item(OP_STOP, '0, '0, '0, '0);
               send_item(OP_START, '0, '0, '0, '0);
            end
            1: send_noise();
            default: begin
            end
         endcase
         rnd = ($urandom_range(0, 15) == 0) ? {RAND_W{$urandom_range(0, 1) == 1}}
                                            : RAND_W'($urandom);
         send_step(rnd);
      end
      send_item(OP_STOP, '0, '0, '0, '0);
      send_step(RAND_W'($urandom));
      if ($urandom_range(0, 3) == 0) send_step(RAND_W'($urandom));
   endtask

   // Output side: random stall modes, plus a long hold-off on request
   initial begin
      stall_mode_type mode;
      int             mode_left;
      int             hold_left;
      rsp_stall = 1'b0;
      mode      = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_stall    = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            case (mode)
               STALL_NONE:  rsp_stall = 1'b0;
               STALL_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall = ($urandom_range(0, 3) != 0);
               default:     rsp_stall = ~rsp_stall;
            endcase
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int song;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_LOAD;
      req_from_code = '0;
      req_to_code   = '0;
      req_weight    = '0;
      req_rand_word = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // initial row: zero weight, extreme codes and weights, rest, sustain, then full
      send_item(OP_LOAD, ROW_INITIAL, 8'd0, 8'd0, '0);
      send_item(OP_LOAD, ROW_INITIAL, 8'd127, 8'd255, '0);
      send_item(OP_LOAD, ROW_INITIAL, CODE_REST, 8'd1, '0);
      send_item(OP_LOAD, ROW_INITIAL, CODE_SUSTAIN, 8'd2, '0);
      for (int n = 60; n < 64; n++) send_item(OP_LOAD, ROW_INITIAL, CODE_W'(n), 8'd10, '0);
      send_item(OP_LOAD, ROW_INITIAL, 8'd64, 8'd5, '0);
      // bad codes are dropped; then a valid load into row 127 and the unused operations
      send_item(OP_LOAD, 8'd131, 8'd5, 8'd7, '0);
      send_item(OP_LOAD, 8'd255, 8'd255, 8'd255, 16'hffff);
      send_item(OP_LOAD, 8'd0, CODE_NONE, 8'd3, '0);
      send_item(OP_LOAD, 8'd127, 8'd0, 8'd1, '0);
      send_item(OP_UNUSED_LO, 8'd1, 8'd1, 8'd1, 16'h1234);
      send_item(OP_UNUSED_HI, 8'd255, 8'd255, 8'd255, 16'hffff);
      // play-state corners
      send_step(16'h0000);
      send_item(OP_START, '0, '0, '0, '0);
      send_item(OP_START, '0, '0, '0, '0);
      send_item(OP_STOP, '0, '0, '0, '0);
      send_item(OP_STOP, '0, '0, '0, '0);
      send_item(OP_START, '0, '0, '0, '0);
      send_step(16'h0000);
      send_step(16'hffff);
      send_step(16'h8000);
      send_item(OP_STOP, '0, '0, '0, '0);
      send_step(16'hffff);
      send_item(OP_CLEAR, '0, '0, '0, '0);

      song = 0;
      while (sent_count < ITEMS) begin
         if ($urandom_range(0, 7) == 0) send_noise();
         play_song(song == 2 || song == 9);
         song++;
      end
      req_valid = 1'b0;

      // drain, then give the block time to show anything extra
      while (pending_events != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== markov_note_sequencer_core.f =====
design/mnsq_pkg.sv
design/mnsq_row_mem.sv
design/mnsq_entry_mem.sv
design/mnsq_ctrl.sv
design/markov_note_sequencer_core.sv
bench/note_event_checker.sv
bench/testbench.sv
